/* rtl/dgp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgp_pkg: shared definitions of the dithered gradient pixel source
// Field widths, register indexes, the 8x8 ordered-dither matrix and the
// payload type of the divider pipeline stages.
// ----------------------------------------------------------------------------
package dgp_pkg;

  // Size limits of the gradient.
  localparam int WIDTH_LIMIT  = 4096;
  localparam int HEIGHT_LIMIT = 4096;

  // Fixed field widths.
  localparam int COL_W     = 12;
  localparam int ROW_W     = 12;
  localparam int COLOR_W   = 8;
  localparam int RGB_W     = 3 * COLOR_W;
  localparam int NCH       = 3;
  localparam int SIZE_REG_W = 13;
  localparam int GAIN_W    = 16;
  localparam int PIX_W     = 32;

  // Effective sizes after clamping to 1..limit.
  localparam int WSIZE_W = $clog2(WIDTH_LIMIT) + 1;
  localparam int HSIZE_W = $clog2(HEIGHT_LIMIT) + 1;

  // Divisor is twice the width; the remainder stays below it.
  localparam int DIV_W = WSIZE_W + 1;
  localparam int REM_W = WSIZE_W;

  // Interpolation datapath: signed color delta times column.
  localparam int PROD_W = COLOR_W + 1 + COL_W + 1;
  localparam int T_W    = PROD_W + 2;
  localparam int N_W    = PROD_W;
  localparam int SUM_W  = N_W + 2;

  // Dither datapath.
  localparam int BAYER_W    = 6;
  localparam int DITHER_MID = 32;
  localparam int DPROD_W    = BAYER_W + 1 + GAIN_W + 1;
  localparam int DSCALE_W   = DPROD_W + 8;
  localparam int DSHIFT     = 14;
  localparam int OFF_W      = DSCALE_W - DSHIFT;

  // Pipeline: input stage, dividend setup, one stage per quotient bit,
  // quotient fixup and final sum with saturation.
  localparam int NUM_STAGES = N_W + 4;
  localparam int DIV0_ST    = 1;
  localparam int F1_ST      = NUM_STAGES - 2;
  localparam int OUT_ST     = NUM_STAGES - 1;

  localparam logic [COLOR_W-1:0] ALPHA     = 8'hFF;
  localparam logic [COLOR_W-1:0] COLOR_MAX = 8'hFF;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RGB_W;

  localparam logic [CFG_IDX_W-1:0] REG_START_RGB    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_RGB      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_GAIN   = 3'd4;

  // 8x8 ordered-dither matrix, indexed by {row[2:0], column[2:0]}.
  localparam logic [BAYER_W-1:0] BAYER [64] = '{
    6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
    6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
  };

  // Payload of one divider stage, all three channels side by side.
  typedef struct packed {
    logic [NCH-1:0]              neg;
    logic [NCH-1:0][N_W-1:0]     num;
    logic [NCH-1:0][N_W-1:0]     quo;
    logic [NCH-1:0][REM_W-1:0]   rem;
    logic signed [OFF_W-1:0]     offset;
    logic                        eof;
  } div_t;

  // Width register value clamped to 1..WIDTH_LIMIT.
  function automatic logic [WSIZE_W-1:0] eff_width(logic [SIZE_REG_W-1:0] v);
    logic [WSIZE_W-1:0] r;
    if (v == '0) begin
      r = WSIZE_W'(1);
    end else if (32'(v) > WIDTH_LIMIT) begin
      r = WSIZE_W'(WIDTH_LIMIT);
    end else begin
      r = WSIZE_W'(v);
    end
    return r;
  endfunction

  // Height register value clamped to 1..HEIGHT_LIMIT.
  function automatic logic [HSIZE_W-1:0] eff_height(logic [SIZE_REG_W-1:0] v);
    logic [HSIZE_W-1:0] r;
    if (v == '0) begin
      r = HSIZE_W'(1);
    end else if (32'(v) > HEIGHT_LIMIT) begin
      r = HSIZE_W'(HEIGHT_LIMIT);
    end else begin
      r = HSIZE_W'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/dgp_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgp_in_if: pixel position channel
// Valid/ready channel that carries one pixel column and row per transaction.
// ----------------------------------------------------------------------------
interface dgp_in_if;
  import dgp_pkg::*;

  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface
`default_nettype wire

/* rtl/dgp_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dgp_out_if: pixel result channel
// Valid/ready channel that carries one ARGB32 pixel and its end-of-frame flag.
// ----------------------------------------------------------------------------
interface dgp_out_if;
  import dgp_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_argb;
  logic             end_of_frame;

  modport source (output valid, output pixel_argb, output end_of_frame, input ready);
  modport sink   (input valid, input pixel_argb, input end_of_frame, output ready);
endinterface
`default_nettype wire

/* rtl/dithered_gradient_pixel.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dithered_gradient_pixel: ordered-dither horizontal gradient pixel source
// Turns a pixel position into an opaque ARGB32 pixel of a dithered gradient.
// ----------------------------------------------------------------------------
// The block takes one pixel position per clock while pos_i.ready is high
// and returns one pixel per transaction, in order, once the position has
// passed every stage. The depth comes from the exact interpolation: each
// channel runs a restoring divider by twice the width, one quotient bit per
// pipeline stage over 22 stages, framed by an input multiply stage, a
// dividend setup stage, a quotient fixup stage and the output stage with the
// dither add and saturation. Every stage holds its own valid bit, so empty
// stages fill up while the output waits and the input stays ready until the
// whole pipeline is full. Registers may be written only while no pixel is in
// flight; zero width or height acts as one.
// ----------------------------------------------------------------------------
module dithered_gradient_pixel (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [dgp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [dgp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  dgp_in_if.sink                           pos_i,
  dgp_out_if.source                        pix_o
);
  import dgp_pkg::*;

  // Configuration registers; sizes are stored already clamped.
  logic [RGB_W-1:0]   start_rgb_q;
  logic [RGB_W-1:0]   end_rgb_q;
  logic [WSIZE_W-1:0] width_q;
  logic [HSIZE_W-1:0] height_q;
  logic [GAIN_W-1:0]  gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_rgb_q <= '0;
      end_rgb_q   <= 24'hFFFFFF;
      width_q     <= WSIZE_W'(256);
      height_q    <= HSIZE_W'(16);
      gain_q      <= GAIN_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_START_RGB:    start_rgb_q <= cfg_wdata_i[RGB_W-1:0];
        REG_END_RGB:      end_rgb_q   <= cfg_wdata_i[RGB_W-1:0];
        REG_IMAGE_WIDTH:  width_q     <= eff_width(cfg_wdata_i[SIZE_REG_W-1:0]);
        REG_IMAGE_HEIGHT: height_q    <= eff_height(cfg_wdata_i[SIZE_REG_W-1:0]);
        REG_NOISE_GAIN:   gain_q      <= cfg_wdata_i[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [DIV_W-1:0] divisor;
  assign divisor = {width_q, 1'b0};

  // Stage enables: a stage loads when it or any stage after it has room.
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] en;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
    assign en[k] = pix_o.ready || !(&valid_q[NUM_STAGES-1:k]);
  end

  assign pos_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= pos_i.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage A: color delta times column, dither level times gain, frame end.
  logic signed [PROD_W-1:0]  a_prod_d [NCH];
  logic signed [PROD_W-1:0]  a_prod_q [NCH];
  logic signed [DPROD_W-1:0] a_dprod_d;
  logic signed [DPROD_W-1:0] a_dprod_q;
  logic                      a_eof_d;
  logic                      a_eof_q;
  logic [BAYER_W-1:0]        bayer_m;
  logic signed [BAYER_W:0]   bayer_c;
  logic signed [GAIN_W:0]    gain_s;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      a_prod_d[c] = ($signed({1'b0, end_rgb_q[c*COLOR_W +: COLOR_W]})
                     - $signed({1'b0, start_rgb_q[c*COLOR_W +: COLOR_W]}))
                    * $signed({1'b0, pos_i.column});
    end
    bayer_m   = BAYER[{pos_i.row[2:0], pos_i.column[2:0]}];
    bayer_c   = $signed({1'b0, bayer_m} - (BAYER_W+1)'(DITHER_MID));
    gain_s    = $signed({1'b0, gain_q});
    a_dprod_d = bayer_c * gain_s;
    a_eof_d   = (WSIZE_W'(pos_i.column) == width_q - WSIZE_W'(1))
             && (HSIZE_W'(pos_i.row) == height_q - HSIZE_W'(1));
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_prod_q  <= a_prod_d;
      a_dprod_q <= a_dprod_d;
      a_eof_q   <= a_eof_d;
    end
  end

  // Divider pipeline; entry zero is the dividend setup stage.
  div_t div_d [N_W+1];
  div_t div_q [N_W+1];

  // Setup: dividend 2*delta*column + width split into sign and magnitude,
  // and the dither offset floor(level*gain*255 / 16384).
  logic signed [T_W-1:0]      t_val [NCH];
  logic [T_W-1:0]             t_abs [NCH];
  logic signed [DSCALE_W-1:0] dscale;

  always_comb begin
    div_d[0] = '0;
    for (int c = 0; c < NCH; c++) begin
      t_val[c] = $signed({a_prod_q[c][PROD_W-1], a_prod_q[c], 1'b0})
               + $signed({{(T_W-WSIZE_W){1'b0}}, width_q});
      t_abs[c] = t_val[c][T_W-1] ? T_W'(-t_val[c]) : T_W'(t_val[c]);
      div_d[0].neg[c] = t_val[c][T_W-1];
      div_d[0].num[c] = t_abs[c][N_W-1:0];
    end
    dscale = $signed({a_dprod_q, 8'b0})
           - $signed({{(DSCALE_W-DPROD_W){a_dprod_q[DPROD_W-1]}}, a_dprod_q});
    div_d[0].offset = dscale[DSCALE_W-1:DSHIFT];
    div_d[0].eof    = a_eof_q;
  end

  // One restoring step per stage: shift in the next dividend bit, subtract
  // the divisor when it fits.
  for (genvar j = 1; j <= N_W; j++) begin : g_div
    logic [DIV_W-1:0] cand [NCH];
    logic [DIV_W-1:0] diff [NCH];
    logic [NCH-1:0]   fits;

    always_comb begin
      div_d[j] = div_q[j-1];
      for (int c = 0; c < NCH; c++) begin
        cand[c] = {div_q[j-1].rem[c], div_q[j-1].num[c][N_W-1]};
        diff[c] = cand[c] - divisor;
        fits[c] = cand[c] >= divisor;
        div_d[j].rem[c] = fits[c] ? diff[c][REM_W-1:0] : cand[c][REM_W-1:0];
        div_d[j].num[c] = {div_q[j-1].num[c][N_W-2:0], 1'b0};
        div_d[j].quo[c] = {div_q[j-1].quo[c][N_W-2:0], fits[c]};
      end
    end
  end

  for (genvar j = 0; j <= N_W; j++) begin : g_div_reg
    always_ff @(posedge clk_i) begin
      if (en[DIV0_ST + j]) begin
        div_q[j] <= div_d[j];
      end
    end
  end

  // Fixup: floor quotient of the signed dividend, added to the start color.
  logic [SUM_W-1:0]          f1_sum_d [NCH];
  logic [SUM_W-1:0]          f1_sum_q [NCH];
  logic signed [OFF_W-1:0]   f1_off_q;
  logic                      f1_eof_q;
  logic [NCH-1:0]            f1_inc;
  logic [SUM_W-1:0]          f1_c0 [NCH];
  logic [SUM_W-1:0]          f1_quo [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      f1_inc[c] = div_q[N_W].neg[c] && (div_q[N_W].rem[c] != '0);
      f1_c0[c]  = SUM_W'(start_rgb_q[c*COLOR_W +: COLOR_W]);
      f1_quo[c] = SUM_W'(div_q[N_W].quo[c]);
      f1_sum_d[c] = div_q[N_W].neg[c]
                  ? f1_c0[c] - f1_quo[c] - SUM_W'(f1_inc[c])
                  : f1_c0[c] + f1_quo[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[F1_ST]) begin
      f1_sum_q <= f1_sum_d;
      f1_off_q <= div_q[N_W].offset;
      f1_eof_q <= div_q[N_W].eof;
    end
  end

  // Output stage: dither offset added and each channel saturated to 0..255.
  logic signed [SUM_W-1:0]  o_val [NCH];
  logic [NCH-1:0][COLOR_W-1:0] o_chan;
  logic [PIX_W-1:0]         pix_q;
  logic                     eof_q;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      o_val[c] = $signed(f1_sum_q[c])
               + $signed({{(SUM_W-OFF_W){f1_off_q[OFF_W-1]}}, f1_off_q});
      if (o_val[c] < 0) begin
        o_chan[c] = '0;
      end else if (o_val[c] > $signed(SUM_W'(COLOR_MAX))) begin
        o_chan[c] = COLOR_MAX;
      end else begin
        o_chan[c] = o_val[c][COLOR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OUT_ST]) begin
      pix_q <= {ALPHA, o_chan[2], o_chan[1], o_chan[0]};
      eof_q <= f1_eof_q;
    end
  end

  assign pix_o.valid        = valid_q[OUT_ST];
  assign pix_o.pixel_argb   = pix_q;
  assign pix_o.end_of_frame = eof_q;

  // The input only stalls when every stage holds a pixel and the output waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pos_i.ready |-> (&valid_q) && !pix_o.ready)
    else $error("input stalled while the pipeline has an empty stage");

  // The last divider step always leaves a remainder below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[DIV0_ST + N_W] |-> (DIV_W'(div_q[N_W].rem[0]) < divisor)
                            && (DIV_W'(div_q[N_W].rem[1]) < divisor)
                            && (DIV_W'(div_q[N_W].rem[2]) < divisor))
    else $error("divider remainder not below the divisor");

  // The stored width is always a usable divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (width_q != '0) && (32'(width_q) <= WIDTH_LIMIT))
    else $error("effective width out of range");

endmodule
`default_nettype wire

/* test/tb_dithered_gradient_pixel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dithered_gradient_pixel: self-checking bench of the gradient pixel source
// Streams pixel positions through the block under several register settings
// and idle patterns. Every accepted position is scored against an in-bench
// computation of the dithered gradient pixel, and the results are matched in
// order as they leave the block.
// ----------------------------------------------------------------------------
module tb_dithered_gradient_pixel;

  localparam int ITEMS_PER_PHASE = 185;
  localparam int NUM_PHASES      = 8;
  localparam int STALL_LIMIT     = 4000;
  localparam int TAIL_CYCLES     = 40;

  // 8x8 ordered-dither thresholds, row-major.
  localparam int DITHER_MAP [64] = '{
    0,  32, 8,  40, 2,  34, 10, 42,
    48, 16, 56, 24, 50, 18, 58, 26,
    12, 44, 4,  36, 14, 46, 6,  38,
    60, 28, 52, 20, 62, 30, 54, 22,
    3,  35, 11, 43, 1,  33, 9,  41,
    51, 19, 59, 27, 49, 17, 57, 25,
    15, 47, 7,  39, 13, 45, 5,  37,
    63, 31, 55, 23, 61, 29, 53, 21
  };

  typedef struct packed {
    logic [dgp_pkg::COL_W-1:0] column;
    logic [dgp_pkg::ROW_W-1:0] row;
  } position_t;

  typedef struct packed {
    logic [dgp_pkg::PIX_W-1:0] argb;
    logic                      eof;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [dgp_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [dgp_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  dgp_in_if  pos_if ();
  dgp_out_if pix_if ();

  dithered_gradient_pixel dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pos_i       (pos_if),
    .pix_o       (pix_if)
  );

  // Shadow copy of the register file, at reset values.
  logic [23:0] start_rgb_q = 24'h000000;
  logic [23:0] end_rgb_q   = 24'hFFFFFF;
  logic [12:0] width_q     = 13'd256;
  logic [12:0] height_q    = 13'd16;
  logic [15:0] gain_q      = 16'd256;

  position_t positions_queued [$];
  pixel_t    pixels_due [$];
  int        mismatch_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        quiet_cycles = 0;
  logic      pos_taken = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    pos_if.valid  = 1'b0;
    pos_if.column = '0;
    pos_if.row    = '0;
    pix_if.ready  = 1'b0;
  end

  // Register value as the block sees it: zero acts as one, large values clamp.
  function automatic int eff_size(logic [12:0] v);
    int s;
    s = int'(v);
    if (s == 0) begin
      s = 1;
    end else if (s > 4096) begin
      s = 4096;
    end
    return s;
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    if (n >= 0) begin
      return n / d;
    end
    return -((-n + d - 1) / d);
  endfunction

  // One color channel: exact rounded interpolation plus dither, saturated.
  function automatic logic [7:0] blend_channel(int c0, int c1, int col, int w,
                                               longint offset);
    longint num;
    longint v;
    num = longint'(c0) * w + longint'(c1 - c0) * col;
    v = floor_quot(2 * num + w, 2 * longint'(w)) + offset;
    if (v < 0) begin
      v = 0;
    end else if (v > 255) begin
      v = 255;
    end
    return 8'(v);
  endfunction

  // Expected pixel for a position under the current register settings.
  function automatic pixel_t shade_pixel(position_t p);
    pixel_t px;
    int w;
    int h;
    int col;
    longint dither;
    col = int'(p.column);
    w = eff_size(width_q);
    h = eff_size(height_q);
    dither = floor_quot(longint'(DITHER_MAP[{p.row[2:0], p.column[2:0]}] - 32)
                        * gain_q * 255, 16384);
    px.argb = {8'hFF,
               blend_channel(start_rgb_q[23:16], end_rgb_q[23:16], col, w, dither),
               blend_channel(start_rgb_q[15:8],  end_rgb_q[15:8],  col, w, dither),
               blend_channel(start_rgb_q[7:0],   end_rgb_q[7:0],   col, w, dither)};
    px.eof = (col == w - 1) && (int'(p.row) == h - 1);
    return px;
  endfunction

  // Random position, weighted towards the frame and its last pixel.
  function automatic position_t pick_position();
    position_t p;
    int w;
    int h;
    int k;
    w = eff_size(width_q);
    h = eff_size(height_q);
    k = $urandom_range(99);
    if (k < 10) begin
      p.column = dgp_pkg::COL_W'(w - 1);
      p.row    = dgp_pkg::ROW_W'(h - 1);
    end else if (k < 70) begin
      p.column = dgp_pkg::COL_W'($urandom_range(w - 1));
      p.row    = dgp_pkg::ROW_W'($urandom_range(h - 1));
    end else if (k < 85) begin
      p.column = dgp_pkg::COL_W'($urandom);
      p.row    = dgp_pkg::ROW_W'($urandom);
    end else begin
      p.column = dgp_pkg::COL_W'(w - 2 + $urandom_range(3));
      p.row    = dgp_pkg::ROW_W'(h - 1 + $urandom_range(1));
    end
    return p;
  endfunction

  function automatic position_t at(int col, int row);
    position_t p;
    p.column = dgp_pkg::COL_W'(col);
    p.row    = dgp_pkg::ROW_W'(row);
    return p;
  endfunction

  // Register write at a falling edge; the shadow copy follows at once.
  task automatic write_reg(logic [dgp_pkg::CFG_IDX_W-1:0] idx, logic [23:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = value;
    case (idx)
      dgp_pkg::REG_START_RGB:    start_rgb_q = value;
      dgp_pkg::REG_END_RGB:      end_rgb_q = value;
      dgp_pkg::REG_IMAGE_WIDTH:  width_q = value[12:0];
      dgp_pkg::REG_IMAGE_HEIGHT: height_q = value[12:0];
      dgp_pkg::REG_NOISE_GAIN:   gain_q = value[15:0];
      default: ;
    endcase
  endtask

  // Settings per phase, extremes first, then random ones.
  task automatic apply_setting(int phase);
    logic [23:0] c0;
    logic [23:0] c1;
    logic [12:0] wd;
    logic [12:0] ht;
    logic [15:0] g;
    c0 = 24'($urandom);
    c1 = 24'($urandom);
    g  = 16'($urandom);
    case (phase)
      1: begin
        c0 = 24'h000000; c1 = 24'hFFFFFF; wd = 13'd1; ht = 13'd1; g = 16'd0;
      end
      2: begin
        c0 = 24'hFFFFFF; c1 = 24'h000000; wd = 13'd4096; ht = 13'd4096; g = 16'hFFFF;
      end
      3: begin
        wd = 13'd0; ht = 13'd0; g = 16'd256;
      end
      4: begin
        wd = 13'h1FFF; ht = 13'h1FFF; g = 16'd1;
      end
      5: begin
        wd = 13'd8; ht = 13'd8;
      end
      6: begin
        wd = 13'($urandom_range(300, 1)); ht = 13'($urandom_range(40, 1));
      end
      default: begin
        wd = 13'($urandom_range(8191)); ht = 13'($urandom_range(8191));
        g = 16'($urandom_range(1024));
      end
    endcase
    write_reg(dgp_pkg::REG_START_RGB, c0);
    write_reg(dgp_pkg::REG_END_RGB, c1);
    write_reg(dgp_pkg::REG_IMAGE_WIDTH, 24'(wd));
    write_reg(dgp_pkg::REG_IMAGE_HEIGHT, 24'(ht));
    write_reg(dgp_pkg::REG_NOISE_GAIN, 24'(g));
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Wait at rising edges until no position is queued or offered and every
  // expected pixel has come back.
  task automatic wait_drained();
    @(posedge clk_i);
    while (positions_queued.size() != 0 || pos_if.valid || pixels_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Main sequence: reset, directed positions, then random phases.
  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: corners, last pixel, past the width and the height.
    positions_queued.push_back(at(0, 0));
    positions_queued.push_back(at(255, 15));
    positions_queued.push_back(at(4095, 4095));
    positions_queued.push_back(at(256, 15));
    positions_queued.push_back(at(255, 16));
    positions_queued.push_back(at(128, 7));
    positions_queued.push_back(at(7, 7));
    positions_queued.push_back(at(0, 4095));
    positions_queued.push_back(at(4095, 0));
    positions_queued.push_back(at(1, 1));
    positions_queued.push_back(at(2, 3));
    positions_queued.push_back(at(200, 5));
    positions_queued.push_back(at(2730, 1365));
    positions_queued.push_back(at(1365, 2730));

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != 0) begin
        wait_drained();
        apply_setting(phase);
      end
      case (phase % 4)
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        3: begin send_idle_pct = 22; recv_stall_pct = 22; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold the source once until the pipeline has emptied completely.
        if (phase == 5 && n == ITEMS_PER_PHASE / 2) begin
          wait_drained();
        end
        positions_queued.push_back(pick_position());
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Position source: offer the next queued position with random gaps.
  always @(negedge clk_i) begin
    position_t nxt;
    if (!pos_if.valid || pos_taken) begin
      if (positions_queued.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = positions_queued.pop_front();
        pos_if.valid  <= 1'b1;
        pos_if.column <= nxt.column;
        pos_if.row    <= nxt.row;
      end else begin
        pos_if.valid <= 1'b0;
      end
    end
    pix_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Score each accepted position transaction.
  always @(posedge clk_i) begin
    pos_taken <= rst_ni && pos_if.valid && pos_if.ready;
    if (rst_ni && pos_if.valid && pos_if.ready) begin
      pixels_due.push_back(shade_pixel({pos_if.column, pos_if.row}));
    end
  end

  // Compare each pixel transaction with the oldest expected pixel.
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel_argb %h end_of_frame %b", pix_if.pixel_argb,
               pix_if.end_of_frame);
        mismatch_count++;
      end else begin
        want = pixels_due.pop_front();
        if (pix_if.pixel_argb !== want.argb) begin
          $error("pixel_argb: expected %h, got %h", want.argb, pix_if.pixel_argb);
          mismatch_count++;
        end
        if (pix_if.end_of_frame !== want.eof) begin
          $error("end_of_frame: expected %b, got %b", want.eof, pix_if.end_of_frame);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pos_if.valid && pos_if.ready) || (pix_if.valid && pix_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
